/* rtl/remote_debug_packet_framer_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the remote-debug packet framer
// Shared property forms; each use expands to one labelled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef REMOTE_DEBUG_PACKET_FRAMER_CORE_MACROS_SVH
`define REMOTE_DEBUG_PACKET_FRAMER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, switched off in reset
`define RDPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdpf: assertion failed");

// Next-cycle implication, sampled on clk, switched off in reset
`define RDPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdpf: assertion failed");

`endif

/* rtl/rdpf_pkg.sv */
// ----------------------------------------------------------------------------
// rdpf_pkg
// Types, character codes and helpers shared by the packet framer modules.
// ----------------------------------------------------------------------------
package rdpf_pkg;

  // Framing characters
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_ESC   = 8'h7D;  // '}'
  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One classified item
  typedef struct packed {
    logic       start;  // emit '$' first
    logic       esc;    // emit '}' before the character
    logic       last;   // append trailer
    logic [7:0] ch;     // character after escaping
    logic [7:0] sum;    // running sum after this item
  } entry_t;

  // Queue status towards its neighbours
  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QCW-1:0] count;
  } queue_status_t;

  // Character slot within one item
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_ESC,
    PH_CHAR,
    PH_HASH,
    PH_HI,
    PH_LO
  } phase_t;

  // Lowercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib > 4'd9) begin
      hex_digit = CH_LA - 8'd10 + wide;
    end else begin
      hex_digit = CH_ZERO + wide;
    end
  endfunction

endpackage

/* rtl/rdpf_front.sv */
// ----------------------------------------------------------------------------
// rdpf_front
// Accepts input transfers, resolves escaping and keeps the running sum.
// ----------------------------------------------------------------------------
module rdpf_front
  import rdpf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] data_byte
  input  logic [1:0]    s_tuser,   // [0] escape_enable, [1] first_byte
  input  logic          s_tlast,   // last_byte
  input  queue_status_t q_status,
  output logic          push,
  output entry_t        push_entry
);

  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic       do_esc;
  logic [7:0] ch;
  logic [7:0] base;

  // Classify the incoming character
  assign do_esc = s_tuser[0] &&
                  (s_tdata == CH_HASH || s_tdata == CH_START || s_tdata == CH_ESC);
  assign ch     = do_esc ? (s_tdata ^ ESC_XOR) : s_tdata;
  assign base   = s_tuser[1] ? 8'h00 : running_sum;

  // Sum after this item: optional escape mark plus the character
  assign running_sum_next = base + (do_esc ? CH_ESC : 8'h00) + ch;

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_entry.start = s_tuser[1];
    push_entry.esc   = do_esc;
    push_entry.last  = s_tlast;
    push_entry.ch    = ch;
    push_entry.sum   = running_sum_next;
  end

  // Running sum register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'h00;
    end else if (push) begin
      running_sum <= running_sum_next;
    end
  end

endmodule

/* rtl/rdpf_queue.sv */
// ----------------------------------------------------------------------------
// rdpf_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rdpf_queue
  import rdpf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  entry_t        push_entry,
  input  logic          pop,
  output entry_t        head,
  output queue_status_t status
);

  entry_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == QCW'(QDEPTH));
  assign status.empty = (count == '0);

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/rdpf_back.sv */
// ----------------------------------------------------------------------------
// rdpf_back
// Walks each queued item one character per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module rdpf_back
  import rdpf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  entry_t        head,
  input  queue_status_t q_status,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,   // [7:0] out_char
  output logic [0:0]    m_tuser,   // [0] packet_end
  output logic          m_tlast    // run_last
);

  phase_t     phase;
  phase_t     phase_next;
  phase_t     cur;
  logic       advance;
  logic       done;
  logic       pend;
  logic [7:0] char_out;

  // Current slot: the registered slot, or the first slot of a fresh item when idle
  always_comb begin
    if (phase == PH_IDLE) begin
      if (head.start) begin
        cur = PH_START;
      end else if (head.esc) begin
        cur = PH_ESC;
      end else begin
        cur = PH_CHAR;
      end
    end else begin
      cur = phase;
    end
  end

  assign advance = (!m_tvalid || m_tready) && !q_status.empty;
  assign pop     = advance && done;

  // Next slot
  always_comb begin
    case (cur)
      PH_START: phase_next = head.esc ? PH_ESC : PH_CHAR;
      PH_ESC:   phase_next = PH_CHAR;
      PH_CHAR:  phase_next = head.last ? PH_HASH : PH_IDLE;
      PH_HASH:  phase_next = PH_HI;
      PH_HI:    phase_next = PH_LO;
      PH_LO:    phase_next = PH_IDLE;
      default:  phase_next = PH_IDLE;
    endcase
  end

  // Character and flags of the current slot
  always_comb begin
    done = 1'b0;
    pend = 1'b0;
    case (cur)
      PH_START: char_out = CH_START;
      PH_ESC:   char_out = CH_ESC;
      PH_CHAR: begin
        char_out = head.ch;
        done     = !head.last;
      end
      PH_HASH:  char_out = CH_HASH;
      PH_HI:    char_out = hex_digit(head.sum[7:4]);
      PH_LO: begin
        char_out = hex_digit(head.sum[3:0]);
        done     = 1'b1;
        pend     = 1'b1;
      end
      default:  char_out = head.ch;
    endcase
  end

  // Slot register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata    <= char_out;
      m_tlast    <= done;
      m_tuser[0] <= pend;
    end
  end

endmodule

/* rtl/remote_debug_packet_framer_core.sv */
// ----------------------------------------------------------------------------
// remote_debug_packet_framer_core
// Frames a byte stream as '$' payload '#' hh with a modulo-256 checksum.
//
//   Channel  Dir  Bus                      Fields (low bit first)
//   s_*      in   tdata[7:0] tuser[1:0]    data_byte | escape_enable, first_byte
//                 tlast                    last_byte
//   m_*      out  tdata[7:0] tuser[0:0]    out_char | packet_end
//                 tlast                    run_last
//
// Each input item emits 1 to 6 characters, set by the back-end character
// sequencer, which emits one character a cycle while the output is not stalled.
// The front accepts a new transfer every cycle while the 4-entry queue has room.
// Reset (rst, synchronous) clears the running sum, queue and sequencer.
// A stalled output holds its transfer; the queue lets the input run ahead.
// ----------------------------------------------------------------------------
`include "remote_debug_packet_framer_core_macros.svh"

module remote_debug_packet_framer_core
  import rdpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic [1:0] s_tuser,   // [0] escape_enable, [1] first_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic [0:0] m_tuser,   // [0] packet_end
  output logic       m_tlast    // run_last
);

  logic          push;
  logic          pop;
  entry_t        push_entry;
  entry_t        head;
  queue_status_t q_status;
  logic          m_is_hex;

  // Front: accept and classify
  rdpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue between the two halves
  rdpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Back: emit characters
  rdpf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Set when the output character is a lowercase hex digit
  assign m_is_hex = (m_tdata >= CH_ZERO && m_tdata <= (CH_ZERO + 8'd9)) ||
                    (m_tdata >= CH_LA && m_tdata <= (CH_LA + 8'd5));

  // Checks
  `RDPF_ASSERT_IMPL(a_pend_is_run_last, m_tvalid && m_tuser[0], m_tlast)
  `RDPF_ASSERT_IMPL(a_pend_is_hex, m_tvalid && m_tuser[0], m_is_hex)
  `RDPF_ASSERT_IMPL(a_queue_bound, 1'b1, q_status.count <= QCW'(QDEPTH))
  `RDPF_ASSERT_NEXT(a_pop_needs_data, pop, $past(!q_status.empty))

endmodule
